// File: design/tdpp_pkg.sv
package tdpp_pkg;

  // Field widths at the ports
  localparam int ANGLE_FIELD_W   = 16;
  localparam int RADIUS_FIELD_W  = 10;
  localparam int POS_X_W         = 12;
  localparam int POS_Y_W         = 11;
  localparam int IN_TDATA_W      = 2 * ANGLE_FIELD_W;
  localparam int OUT_TDATA_W     = 24;

  // Defaults for the top level parameters
  localparam int ANGLE_BITS_DEF  = 16;
  localparam int RADIUS_BITS_DEF = 10;
  localparam logic [RADIUS_FIELD_W-1:0] RADIUS_RESET = 10'd400;
  localparam int RIGHT_CENTRE_MULT = 3;

  // Q30 fixed point
  localparam int FRAC_W = 30;
  localparam logic [31:0] PI30 = 32'd3373259426;
  localparam logic [FRAC_W:0] Q_ONE = 31'h4000_0000;

  // Taylor step divisors, Horner order
  localparam int SIN_STEPS = 4;
  localparam int COS_STEPS = 5;
  localparam int SIN_K [SIN_STEPS] = '{72, 42, 20, 6};
  localparam int COS_K [COS_STEPS] = '{90, 56, 30, 12, 2};

  // Register stages
  localparam int CELL_LAT = 3;
  localparam int TRIG_LAT = 3 + COS_STEPS * CELL_LAT;
  localparam int PIPE_LAT = TRIG_LAT + 2;

  typedef struct packed {
    logic [FRAC_W:0] sin_mag;
    logic            sin_neg;
    logic [FRAC_W:0] cos_mag;
    logic            cos_neg;
  } trig_t;

endpackage

// File: design/tdpp_delay.sv
module tdpp_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

// File: design/tdpp_horner_cell.sv
// One Horner step: t_o = 1 - floor(floor(x2*t_i)/K), three register stages.
module tdpp_horner_cell #(
  parameter int K = 2
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [tdpp_pkg::FRAC_W-1:0] x2_i,
  input  logic [tdpp_pkg::FRAC_W:0]   t_i,
  output logic [tdpp_pkg::FRAC_W-1:0] x2_o,
  output logic [tdpp_pkg::FRAC_W:0]   t_o
);

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);
  localparam logic [29:0] KV    = 30'(K);

  logic [60:0] prod_a;
  logic [61:0] prod_b;
  logic [29:0] rem_c;
  logic [29:0] quo_c;

  logic [29:0] x2_a_r, x2_b_r, x2_c_r;
  logic [29:0] p_a_r, p_b_r, q0_b_r;
  logic [30:0] t_c_r;

  always_comb begin
    prod_a = 61'(x2_i) * 61'(t_i);
    prod_b = 62'(p_a_r) * 62'(RECIP);
    // reciprocal estimate is low by at most one
    rem_c  = p_b_r - 30'(q0_b_r * KV);
    quo_c  = (rem_c >= KV) ? q0_b_r + 30'd1 : q0_b_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_a_r  <= prod_a[59:30];
      x2_a_r <= x2_i;
      q0_b_r <= prod_b[61:32];
      p_b_r  <= p_a_r;
      x2_b_r <= x2_a_r;
      t_c_r  <= tdpp_pkg::Q_ONE - {1'b0, quo_c};
      x2_c_r <= x2_b_r;
    end
  end

  assign x2_o = x2_c_r;
  assign t_o  = t_c_r;

endmodule

// File: design/tdpp_trig.sv
// Sine and cosine of a binary angle, Q30 magnitude plus sign.
module tdpp_trig #(
  parameter int ANGLE_BITS = tdpp_pkg::ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS-1:0] angle,
  output tdpp_pkg::trig_t       trig
);

  localparam int SN = tdpp_pkg::SIN_STEPS;
  localparam int CN = tdpp_pkg::COS_STEPS;
  localparam int CL = tdpp_pkg::CELL_LAT;
  localparam logic [ANGLE_BITS-2:0] QUARTER = (ANGLE_BITS-1)'(1) << (ANGLE_BITS-2);
  localparam logic [ANGLE_BITS-3:0] HALF    = (ANGLE_BITS-2)'(1) << (ANGLE_BITS-3);

  logic [1:0]            quad;
  logic [ANGLE_BITS-3:0] off;
  logic                  swap;
  logic [ANGLE_BITS-3:0] off_f;
  logic [ANGLE_BITS+29:0] th_prod;
  logic [59:0]           sq_prod;
  logic [60:0]           s_prod;

  logic [29:0] th0_r, th1_r, x2_1_r;
  logic [1:0]  quad0_r, quad1_r;
  logic        swap0_r, swap1_r;
  logic [30:0] s_fin_r;
  tdpp_pkg::trig_t trig_r;

  logic [29:0] sx2 [SN+1];
  logic [30:0] st  [SN+1];
  logic [29:0] cx2 [CN+1];
  logic [30:0] ct  [CN+1];

  logic [29:0] th_d;
  logic [30:0] s_d;
  logic [2:0]  qs_d;
  logic [30:0] s_sw, c_sw;

  always_comb begin
    quad    = angle[ANGLE_BITS-1 -: 2];
    off     = angle[ANGLE_BITS-3:0];
    swap    = off > HALF;
    off_f   = swap ? (ANGLE_BITS-2)'(QUARTER - {1'b0, off}) : off;
    th_prod = (ANGLE_BITS+30)'(off_f) * (ANGLE_BITS+30)'(tdpp_pkg::PI30);
    sq_prod = 60'(th0_r) * 60'(th0_r);
    s_prod  = 61'(th_d) * 61'(st[SN]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      th0_r   <= th_prod[ANGLE_BITS+28:ANGLE_BITS-1];
      quad0_r <= quad;
      swap0_r <= swap;
      th1_r   <= th0_r;
      x2_1_r  <= sq_prod[59:30];
      quad1_r <= quad0_r;
      swap1_r <= swap0_r;
      s_fin_r <= s_prod[60:30];
    end
  end

  assign sx2[0] = x2_1_r;
  assign st[0]  = tdpp_pkg::Q_ONE;
  assign cx2[0] = x2_1_r;
  assign ct[0]  = tdpp_pkg::Q_ONE;

  for (genvar i = 0; i < SN; i++) begin : g_sin
    tdpp_horner_cell #(.K(tdpp_pkg::SIN_K[i])) u_cell (
      .clk(clk), .en(en), .x2_i(sx2[i]), .t_i(st[i]), .x2_o(sx2[i+1]), .t_o(st[i+1])
    );
  end

  for (genvar i = 0; i < CN; i++) begin : g_cos
    tdpp_horner_cell #(.K(tdpp_pkg::COS_K[i])) u_cell (
      .clk(clk), .en(en), .x2_i(cx2[i]), .t_i(ct[i]), .x2_o(cx2[i+1]), .t_o(ct[i+1])
    );
  end

  tdpp_delay #(.W(30), .DEPTH(SN * CL)) u_th_dly (
    .clk(clk), .en(en), .d(th1_r), .q(th_d)
  );

  tdpp_delay #(.W(31), .DEPTH((CN - SN) * CL - 1)) u_sin_dly (
    .clk(clk), .en(en), .d(s_fin_r), .q(s_d)
  );

  tdpp_delay #(.W(3), .DEPTH(CN * CL)) u_qs_dly (
    .clk(clk), .en(en), .d({swap1_r, quad1_r}), .q(qs_d)
  );

  // unfold the octant, then the quadrant signs
  always_comb begin
    s_sw = qs_d[2] ? ct[CN] : s_d;
    c_sw = qs_d[2] ? s_d : ct[CN];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (qs_d[1:0])
        2'd0: trig_r <= '{sin_mag: s_sw, sin_neg: 1'b0, cos_mag: c_sw, cos_neg: 1'b0};
        2'd1: trig_r <= '{sin_mag: c_sw, sin_neg: 1'b0, cos_mag: s_sw, cos_neg: 1'b1};
        2'd2: trig_r <= '{sin_mag: s_sw, sin_neg: 1'b1, cos_mag: c_sw, cos_neg: 1'b1};
        default: trig_r <= '{sin_mag: c_sw, sin_neg: 1'b1, cos_mag: s_sw, cos_neg: 1'b0};
      endcase
    end
  end

  assign trig = trig_r;

endmodule

// File: design/twin_disc_polar_projection_unit.sv
// Pipeline: 18 trig stages, 2 placement stages, then the output register.
// Throughput: one item per cycle while the skid is empty; the 3-stage Horner cells
//   and the multipliers are all pipelined, so the pipe takes an item every cycle unless stalled.
// A 1-entry skid behind the output register absorbs one stalled item.
// Reset (rst_n low, synchronous) empties the pipe and skid, radius -> 400.
module twin_disc_polar_projection_unit #(
  parameter int ANGLE_BITS  = tdpp_pkg::ANGLE_BITS_DEF,
  parameter int RADIUS_BITS = tdpp_pkg::RADIUS_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // configuration: disc_radius
  input  logic                                  cfg_wr_en,
  input  logic [tdpp_pkg::RADIUS_FIELD_W-1:0]   cfg_wr_data,
  // input items
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [tdpp_pkg::IN_TDATA_W-1:0]       in_tdata,   // latitude, longitude
  // result items
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [tdpp_pkg::OUT_TDATA_W-1:0]      out_tdata,  // pos_x, pos_y, pad
  output logic                                  out_tuser   // right_disc
);

  localparam int PW = RADIUS_BITS + 34;  // placement sum width, Q30
  localparam int CW = RADIUS_BITS + 2;   // centre width
  localparam int MW = RADIUS_BITS + 31;  // scaled offset width
  localparam int FW = tdpp_pkg::ANGLE_FIELD_W;
  localparam int XW = tdpp_pkg::POS_X_W;
  localparam int YW = tdpp_pkg::POS_Y_W;
  localparam int FB = tdpp_pkg::FRAC_W;

  logic [tdpp_pkg::RADIUS_FIELD_W-1:0] disc_radius_r;
  logic [RADIUS_BITS-1:0] radius;

  logic en;
  logic accept;
  logic [tdpp_pkg::PIPE_LAT-1:0] vld_r;

  logic [ANGLE_BITS-1:0] lat, lng;
  logic right_in, right_d;

  tdpp_pkg::trig_t lat_trig, lng_trig;

  logic [30:0] px_r, py_r;
  logic        negx_r, negy_r, negx2_r, negy2_r;
  logic [61:0] px_prod, py_prod;
  logic [MW-1:0] magx_r, magy_r;

  logic [CW-1:0] cx, cy;
  logic [PW-1:0] basex, basey, mx, my, posx, posy;
  logic [tdpp_pkg::OUT_TDATA_W-1:0] res_data;

  logic [tdpp_pkg::OUT_TDATA_W-1:0] out_data_r, skid_data_r;
  logic out_user_r, skid_user_r, out_vld_r, skid_vld_r;
  logic out_free;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disc_radius_r <= tdpp_pkg::RADIUS_RESET;
    end else if (cfg_wr_en) begin
      disc_radius_r <= cfg_wr_data;
    end
  end

  assign radius = RADIUS_BITS'(disc_radius_r);

  // whole pipe advances unless the skid holds an item
  assign en        = !skid_vld_r;
  assign in_tready = en;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[tdpp_pkg::PIPE_LAT-2:0], accept};
    end
  end

  assign lat = ANGLE_BITS'(signed'(in_tdata[FW-1:0]));
  assign lng = ANGLE_BITS'(signed'(in_tdata[2*FW-1:FW]));
  // right disc only for strictly positive latitude
  assign right_in = (lat != '0) && !lat[ANGLE_BITS-1];

  tdpp_trig #(.ANGLE_BITS(ANGLE_BITS)) u_lat_trig (
    .clk(clk), .en(en), .angle(lat), .trig(lat_trig)
  );

  tdpp_trig #(.ANGLE_BITS(ANGLE_BITS)) u_lng_trig (
    .clk(clk), .en(en), .angle(lng), .trig(lng_trig)
  );

  tdpp_delay #(.W(1), .DEPTH(tdpp_pkg::PIPE_LAT)) u_right_dly (
    .clk(clk), .en(en), .d(right_in), .q(right_d)
  );

  // ring * trig, then scale by radius
  always_comb begin
    px_prod = 62'(lat_trig.cos_mag) * 62'(lng_trig.cos_mag);
    py_prod = 62'(lat_trig.cos_mag) * 62'(lng_trig.sin_mag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r    <= px_prod[60:30];
      py_r    <= py_prod[60:30];
      negx_r  <= lat_trig.cos_neg ^ lng_trig.cos_neg;
      negy_r  <= lat_trig.cos_neg ^ lng_trig.sin_neg;
      magx_r  <= MW'(px_r) * MW'(radius);
      magy_r  <= MW'(py_r) * MW'(radius);
      negx2_r <= negx_r;
      negy2_r <= negy_r;
    end
  end

  // add offset to centre, clamp below at zero, drop fraction
  always_comb begin
    cx    = right_d ? CW'(radius) * CW'(tdpp_pkg::RIGHT_CENTRE_MULT) : CW'(radius);
    cy    = CW'(radius);
    basex = PW'(cx) << FB;
    basey = PW'(cy) << FB;
    mx    = PW'(magx_r);
    my    = PW'(magy_r);
    if (negx2_r) begin
      posx = (mx > basex) ? '0 : basex - mx;
    end else begin
      posx = basex + mx;
    end
    if (negy2_r) begin
      posy = (my > basey) ? '0 : basey - my;
    end else begin
      posy = basey + my;
    end
    res_data = {1'b0, posy[FB+YW-1:FB], posx[FB+XW-1:FB]};
  end

  // output register plus skid
  assign out_free = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_free) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end
    end else if (vld_r[tdpp_pkg::PIPE_LAT-1]) begin
      if (out_free) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_free) begin
        out_data_r <= skid_data_r;
        out_user_r <= skid_user_r;
      end
    end else if (vld_r[tdpp_pkg::PIPE_LAT-1]) begin
      if (out_free) begin
        out_data_r <= res_data;
        out_user_r <= right_d;
      end else begin
        skid_data_r <= res_data;
        skid_user_r <= right_d;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// File: design/tdpp_checker.sv
module tdpp_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [tdpp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic                               out_tuser
);

  // stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // input side only blocks while a result is pending
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input blocked with output empty");

  // skid drains only when a result was taken
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && in_tready && !$past(in_tready) |-> $past(out_tvalid && out_tready))
    else $error("skid drained without output handshake");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind twin_disc_polar_projection_unit tdpp_checker u_tdpp_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int QUARTER    = 1 << (tdpp_pkg::ANGLE_BITS_DEF - 2);
  localparam int IDLE_LIMIT = 3000;   // cycles with no accept on either side
  localparam int DRAIN_WAIT = tdpp_pkg::PIPE_LAT + 20;
  localparam int LONG_HOLD  = 300;    // receiver stall that backs up the pipe

  typedef struct packed {
    logic [tdpp_pkg::ANGLE_FIELD_W-1:0] lng;
    logic [tdpp_pkg::ANGLE_FIELD_W-1:0] lat;
  } point_t;

  typedef struct packed {
    logic [tdpp_pkg::POS_X_W-1:0] pos_x;
    logic [tdpp_pkg::POS_Y_W-1:0] pos_y;
    logic                         right_disc;
  } spot_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [tdpp_pkg::RADIUS_FIELD_W-1:0] cfg_wr_data;
  logic in_tvalid;
  logic in_tready;
  logic [tdpp_pkg::IN_TDATA_W-1:0] in_tdata;     // latitude, longitude
  logic out_tvalid;
  logic out_tready;
  logic [tdpp_pkg::OUT_TDATA_W-1:0] out_tdata;   // pos_x, pos_y, pad
  logic out_tuser;                               // right_disc

  point_t pending_points[$];
  spot_t  expected_spots[$];
  int unsigned radius_now;   // radius the block holds, tracked here
  int errors = 0;
  int spots_seen;
  bit calm;                  // no idling in the tail of the run
  bit long_hold_done = 1'b0;
  int send_gap;
  int recv_gap;
  int recv_hold;
  int idle_cycles;

  twin_disc_polar_projection_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Q30 sine/cosine of a binary angle: octant folding plus Horner Taylor terms
  function automatic void sincos_q30(input logic [tdpp_pkg::ANGLE_FIELD_W-1:0] ang,
                                     output longint sn, output longint cs);
    longint unsigned r, th, x2, t, s, c, tmp;
    logic [1:0] quad;
    longint unsigned ks[4];
    longint unsigned kc[5];
    ks = '{72, 42, 20, 6};
    kc = '{90, 56, 30, 12, 2};
    quad = ang[tdpp_pkg::ANGLE_FIELD_W-1 -: 2];
    r = ang & (QUARTER - 1);
    tmp = 0;
    if (r > QUARTER / 2) begin
      r = QUARTER - r;
      tmp = 1;
    end
    th = (r * longint'(tdpp_pkg::PI30)) >> (tdpp_pkg::ANGLE_BITS_DEF - 1);
    x2 = (th * th) >> tdpp_pkg::FRAC_W;
    t = 64'd1 << tdpp_pkg::FRAC_W;
    for (int i = 0; i < 4; i++)
      t = (64'd1 << tdpp_pkg::FRAC_W) - ((x2 * t) >> tdpp_pkg::FRAC_W) / ks[i];
    s = (th * t) >> tdpp_pkg::FRAC_W;
    t = 64'd1 << tdpp_pkg::FRAC_W;
    for (int i = 0; i < 5; i++)
      t = (64'd1 << tdpp_pkg::FRAC_W) - ((x2 * t) >> tdpp_pkg::FRAC_W) / kc[i];
    c = t;
    if (tmp != 0) begin
      tmp = s;
      s = c;
      c = tmp;
    end
    case (quad)
      2'd0: begin sn = s;  cs = c;  end
      2'd1: begin sn = c;  cs = -s; end
      2'd2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  // centre + radius*a*b, floored, negative clamped to zero
  function automatic longint unsigned offset_coord(longint unsigned centre, longint a,
                                                   longint b, longint unsigned rad);
    longint unsigned ma, mb, mag, base;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    mag = ((ma * mb) >> tdpp_pkg::FRAC_W) * rad;
    base = centre << tdpp_pkg::FRAC_W;
    if ((a < 0) != (b < 0))
      return (mag > base) ? 0 : (base - mag) >> tdpp_pkg::FRAC_W;
    return (base + mag) >> tdpp_pkg::FRAC_W;
  endfunction

  function automatic spot_t project_point(point_t p, int unsigned rad);
    longint s_lat, c_lat, s_lng, c_lng;
    longint unsigned cx;
    spot_t sp;
    sincos_q30(p.lat, s_lat, c_lat);
    sincos_q30(p.lng, s_lng, c_lng);
    sp.right_disc = (p.lat != 0) && !p.lat[tdpp_pkg::ANGLE_FIELD_W-1];
    cx = sp.right_disc ? tdpp_pkg::RIGHT_CENTRE_MULT * rad : rad;
    sp.pos_x = tdpp_pkg::POS_X_W'(offset_coord(cx, c_lat, c_lng, rad));
    sp.pos_y = tdpp_pkg::POS_Y_W'(offset_coord(rad, c_lat, s_lng, rad));
    return sp;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: offers the head of pending_points, pops it on accept
  always @(posedge clk) begin
    bit offer;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      send_gap  = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_spots = {expected_spots, project_point(point_t'(in_tdata), radius_now)};
        void'(pending_points.pop_front());
      end
      offer = 1'b0;
      if (in_tvalid && !in_tready) begin
        offer = 1'b1;   // an offered item stays until taken
      end else if (send_gap > 0) begin
        send_gap--;
      end else if (pending_points.size() > 0) begin
        if (!calm && $urandom_range(15) == 0) send_gap = $urandom_range(14, 1);
        else offer = 1'b1;
      end
      in_tvalid <= offer;
      if (offer) in_tdata <= pending_points[0];
    end
  end

  // Receiver: random stall bursts plus one long hold-off to back up the pipe
  always @(posedge clk) begin
    bit rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap   = 0;
      recv_hold  = 0;
      spots_seen = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        spot_t got, want;
        got.pos_x = out_tdata[tdpp_pkg::POS_X_W-1:0];
        got.pos_y = out_tdata[tdpp_pkg::POS_X_W +: tdpp_pkg::POS_Y_W];
        got.right_disc = out_tuser;
        spots_seen++;
        if (expected_spots.size() == 0) begin
          if (errors < 10) $display("unexpected item: x=%0d y=%0d r=%0d",
                                    got.pos_x, got.pos_y, got.right_disc);
          errors++;
        end else begin
          want = expected_spots.pop_front();
          if (got !== want) begin
            if (errors < 10)
              $display("mismatch: exp x=%0d y=%0d r=%0d, got x=%0d y=%0d r=%0d",
                       want.pos_x, want.pos_y, want.right_disc,
                       got.pos_x, got.pos_y, got.right_disc);
            errors++;
          end
        end
        if (spots_seen == 100 && !long_hold_done) begin
          long_hold_done = 1'b1;
          recv_hold = LONG_HOLD;
        end
      end
      rdy = 1'b1;
      if (recv_hold > 0) begin
        recv_hold--;
        rdy = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rdy = 1'b0;
      end else if (!calm && $urandom_range(11) == 0) begin
        recv_gap = $urandom_range(14, 1) - 1;
        rdy = 1'b0;
      end
      out_tready <= rdy;
    end
  end

  // Watchdog on cycles without progress
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
      idle_cycles = 0;
    else if (++idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_radius(int unsigned value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= tdpp_pkg::RADIUS_FIELD_W'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    radius_now  = value & ((1 << tdpp_pkg::RADIUS_FIELD_W) - 1);
  endtask

  // wait until every point is sent and every spot has come back
  task automatic drain();
    while (pending_points.size() > 0 || expected_spots.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic add_point(int lat, int lng);
    point_t p;
    p.lat = tdpp_pkg::ANGLE_FIELD_W'(lat);
    p.lng = tdpp_pkg::ANGLE_FIELD_W'(lng);
    pending_points = {pending_points, p};
  endtask

  initial begin
    int unsigned radii[6];
    int lats[10];
    int lngs[8];
    radii = '{400, 1023, 1, 0, 0, 511};
    lats  = '{-16384, 0, 1, -1, 16384, 8192, -8192, 16385, -32768, 32767};
    lngs  = '{0, 16384, -32768, 32767, -16384, 4096, 4097, 12288};
    calm = 1'b0;
    radius_now = tdpp_pkg::RADIUS_RESET;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset radius, angle extremes, poles, equator, octant edges,
    // latitude outside its range
    for (int i = 0; i < 10; i++) add_point(lats[i], lngs[i % 8]);
    for (int i = 0; i < 8; i++) add_point(lats[(i * 3) % 10], lngs[i]);
    add_point(16384, 8192);
    add_point(-16384, -8192);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 4) radii[ph] = $urandom_range(1023, 2);
      if (ph > 0 || radii[ph] != tdpp_pkg::RADIUS_RESET) write_radius(radii[ph]);
      if (ph == 0) write_radius(400);
      for (int n = 0; n < 305; n++) begin
        if (ph == 5 && n == 150) begin
          while (pending_points.size() > 0) @(posedge clk);
          calm = 1'b1;
        end
        if ($urandom_range(4) == 0)
          add_point($urandom_range(65535), $urandom_range(65535));
        else
          add_point(int'($urandom_range(32768)) - 16384, $urandom_range(65535));
      end
      drain();   // sender pauses until every result is back
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/tdpp_pkg.sv
design/tdpp_delay.sv
design/tdpp_horner_cell.sv
design/tdpp_trig.sv
design/twin_disc_polar_projection_unit.sv
design/tdpp_checker.sv
tb/tb.sv
